>>> hdl/rmd_pkg.sv
// Package for the rational multiply/divide block.
// Holds widths, the controller state type and the command/status structs.
// No dependencies.
package rmd_pkg;

	// Operand width in bits (two's complement numerator or denominator)
	localparam int OPW = 16;

	// Cross product, its magnitude, and the result fields
	localparam int PROD_W    = 2 * OPW;
	localparam int MAG_W     = PROD_W - 1;
	localparam int RES_NUM_W = PROD_W;
	localparam int RES_DEN_W = MAG_W;

	// Shift count of the binary gcd and the divider bit counter
	localparam int K_W   = $clog2(MAG_W);
	localparam int CNT_W = $clog2(MAG_W + 1);

	// Stream words, padded to whole bytes
	localparam int IN_DATA_W  = ((4 * OPW + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

	// Request kinds
	localparam logic REQ_MUL = 1'b0;
	localparam logic REQ_DIV = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_PREP,
		ST_GCD,
		ST_DIV,
		ST_FINISH
	} rmd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic mult;
		logic prep;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} rmd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic zero_den;
		logic gcd_done;
		logic div_done;
		logic out_free;
	} rmd_stat_t;

endpackage

>>> hdl/rational_mul_div.sv
// Rational multiply/divide: reduced product or quotient of two signed fractions.
//
// Input stream (s_*): one word per request. s_tuser is the request kind
// (0 multiply, 1 divide left by right); s_tdata carries four signed 16-bit
// operands. Output stream (m_*): one word per request with the reduced
// fraction; the denominator is positive, and m_tuser flags a zero product
// denominator, in which case the fraction reads 0/1.
// Timing: one request at a time. From acceptance a result is registered after
// the multiply, the magnitude prep, the binary gcd steps (one per cycle), a gcd
// exit, one divide step per quotient bit plus a divide exit, and the output
// load. A zero denominator skips gcd and divide: prep goes straight to the load.
// The next word is accepted in the cycle after the load at the earliest. The gcd
// loop and the bit-serial divider set the rate.
// s_tready is high only while the block is idle.
// The output register holds its word until taken; a stalled receiver leaves
// the block able to accept and compute the next request, which then waits in
// its final state until the output register frees.
// Reset (arst_n low, asynchronous) returns the controller to idle and drops
// m_tvalid; no clearing pass is needed.
module rational_mul_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// lhs_num [15:0], lhs_den [31:16], rhs_num [47:32], rhs_den [63:48]
	input  logic [rmd_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_num [31:0], res_den [62:32], zero padding [63]
	output logic [rmd_pkg::OUT_DATA_W-1:0] m_tdata,
	// zero_den_error [0]
	output logic                           m_tuser
);
	import rmd_pkg::*;

	rmd_cmd_t  cmd;
	rmd_stat_t stat;

	rmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmd_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// One request in flight: an accepted word drops ready
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a request is in flight");

	// Error results always read 0/1
	a_err_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
		(m_tdata[RES_NUM_W-1:0] == '0) &&
		(m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] == RES_DEN_W'(1)))
		else $error("error result is not 0/1");

	// A good result has a nonzero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] != '0))
		else $error("zero denominator without error flag");

	// The output register is only loaded when free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output word overwritten before taken");

endmodule

>>> hdl/rmd_ctrl.sv
// Controller state machine for the rational multiply/divide block.
// Sequences multiply, magnitude prep, binary gcd, divide and output load.
// Depends on rmd_pkg.
module rmd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  rmd_pkg::rmd_stat_t stat,
	output rmd_pkg::rmd_cmd_t  cmd
);
	import rmd_pkg::*;

	rmd_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_MULT;
			end
			ST_MULT: begin
				state_nxt = ST_PREP;
			end
			ST_PREP: begin
				state_nxt = stat.zero_den ? ST_FINISH : ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_GCD: begin
				cmd.div_init = stat.gcd_done;
				cmd.gcd_step = !stat.gcd_done;
			end
			ST_DIV: begin
				cmd.div_step = !stat.div_done;
			end
			ST_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hdl/rmd_datapath.sv
// Datapath for the rational multiply/divide block: cross products,
// binary gcd, two-lane restoring divider and the output register.
// Depends on rmd_pkg.
module rmd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rmd_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	output logic [rmd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  rmd_pkg::rmd_cmd_t                cmd,
	output rmd_pkg::rmd_stat_t               stat
);
	import rmd_pkg::*;

	// Input word
	logic              req_q;
	logic signed [OPW-1:0] lnum_q, lden_q, rnum_q, rden_q;

	// Cross products
	logic signed [PROD_W-1:0] p_q, q_q;
	logic signed [OPW-1:0]    mul_pa, mul_pb, mul_qa, mul_qb;
	logic signed [PROD_W-1:0] prod_p, prod_q;

	// Magnitudes, gcd and divider
	logic [PROD_W-1:0] p_abs, q_abs;
	logic [MAG_W-1:0]  mn_q, md_q, a_q, b_q, g_q;
	logic [K_W-1:0]    k_q;
	logic              neg_q, err_q;
	logic [MAG_W-1:0]  a_nxt, b_nxt, diff_ab, diff_ba;
	logic [K_W-1:0]    k_nxt;
	logic [MAG_W-1:0]  nq_q, dq_q, rem_n_q, rem_d_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W:0]    rsh_n, rsh_d, rsub_n, rsub_d;
	logic              ge_n, ge_d;

	// Output register
	logic                 out_valid_q;
	logic [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0] res_den_q;
	logic                 err_out_q;
	logic [RES_NUM_W-1:0] num_ext, num_fin;

	// Operand selection: divide swaps the right operand
	always_comb begin
		mul_pa = lnum_q;
		mul_qa = lden_q;
		mul_pb = (req_q == REQ_DIV) ? rden_q : rnum_q;
		mul_qb = (req_q == REQ_DIV) ? rnum_q : rden_q;
		prod_p = PROD_W'(mul_pa) * PROD_W'(mul_pb);
		prod_q = PROD_W'(mul_qa) * PROD_W'(mul_qb);
	end

	// Magnitudes of the products
	assign p_abs = p_q[PROD_W-1] ? PROD_W'(-p_q) : PROD_W'(p_q);
	assign q_abs = q_q[PROD_W-1] ? PROD_W'(-q_q) : PROD_W'(q_q);

	// One binary gcd step
	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;
	always_comb begin
		a_nxt = a_q;
		b_nxt = b_q;
		k_nxt = k_q;
		if (!a_q[0] && !b_q[0]) begin
			a_nxt = a_q >> 1;
			b_nxt = b_q >> 1;
			k_nxt = k_q + K_W'(1);
		end else if (!a_q[0]) begin
			a_nxt = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nxt = b_q >> 1;
		end else if (a_q >= b_q) begin
			a_nxt = diff_ab >> 1;
		end else begin
			b_nxt = diff_ba >> 1;
		end
	end

	// Restoring divide, both lanes share the divisor
	always_comb begin
		rsh_n  = {rem_n_q, nq_q[MAG_W-1]};
		rsh_d  = {rem_d_q, dq_q[MAG_W-1]};
		ge_n   = rsh_n >= {1'b0, g_q};
		ge_d   = rsh_d >= {1'b0, g_q};
		rsub_n = rsh_n - {1'b0, g_q};
		rsub_d = rsh_d - {1'b0, g_q};
	end

	// Final numerator with sign; zero stays positive
	always_comb begin
		num_ext = {1'b0, nq_q};
		num_fin = (neg_q && (nq_q != '0)) ? RES_NUM_W'(-num_ext) : num_ext;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q  <= s_tuser;
			lnum_q <= s_tdata[OPW-1:0];
			lden_q <= s_tdata[2*OPW-1:OPW];
			rnum_q <= s_tdata[3*OPW-1:2*OPW];
			rden_q <= s_tdata[4*OPW-1:3*OPW];
		end
		if (cmd.mult) begin
			p_q <= prod_p;
			q_q <= prod_q;
		end
		if (cmd.prep) begin
			mn_q  <= p_abs[MAG_W-1:0];
			md_q  <= q_abs[MAG_W-1:0];
			a_q   <= p_abs[MAG_W-1:0];
			b_q   <= q_abs[MAG_W-1:0];
			k_q   <= '0;
			neg_q <= p_q[PROD_W-1] ^ q_q[PROD_W-1];
			err_q <= (q_q == '0);
		end
		if (cmd.gcd_step) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
			k_q <= k_nxt;
		end
		if (cmd.div_init) begin
			g_q     <= MAG_W'(b_q << k_q);
			nq_q    <= mn_q;
			dq_q    <= md_q;
			rem_n_q <= '0;
			rem_d_q <= '0;
		end
		if (cmd.div_step) begin
			rem_n_q <= ge_n ? rsub_n[MAG_W-1:0] : rsh_n[MAG_W-1:0];
			rem_d_q <= ge_d ? rsub_d[MAG_W-1:0] : rsh_d[MAG_W-1:0];
			nq_q    <= {nq_q[MAG_W-2:0], ge_n};
			dq_q    <= {dq_q[MAG_W-2:0], ge_d};
		end
		if (cmd.out_load) begin
			res_num_q <= err_q ? '0 : num_fin;
			res_den_q <= err_q ? RES_DEN_W'(1) : dq_q;
			err_out_q <= err_q;
		end
	end

	// Divider bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= CNT_W'(MAG_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status to the controller
	always_comb begin
		stat.zero_den = (q_q == '0);
		stat.gcd_done = (a_q == '0);
		stat.div_done = (cnt_q == '0);
		stat.out_free = !out_valid_q || m_tready;
	end

	// Output word packing
	always_comb begin
		m_tdata = '0;
		m_tdata[RES_NUM_W-1:0] = res_num_q;
		m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] = res_den_q;
	end
	assign m_tuser  = err_out_q;
	assign m_tvalid = out_valid_q;

endmodule
